### rtl/gld_pkg.sv
// Package for the GIF LZW pixel decoder: codes, constants and shared types.
// No dependencies; used by every module under rtl/.
`default_nettype none
package gld_pkg;

	localparam int TABLE_ENTRIES = 4096;
	localparam int MAX_BURST     = 63;
	localparam int MAX_DIM       = 16384;

	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_BYTE   = 2'd1,
		CMD_RESUME = 2'd2,
		CMD_SPARE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_PIXEL    = 3'd0,
		ST_WANTS    = 3'd1,
		ST_PAUSED   = 3'd2,
		ST_ENDED    = 3'd3,
		ST_UNDEF    = 3'd4,
		ST_NOT_ROOT = 3'd5,
		ST_REFUSED  = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		REG_MCS    = 3'd0,
		REG_LEFT   = 3'd1,
		REG_TOP    = 3'd2,
		REG_WIDTH  = 3'd3,
		REG_HEIGHT = 3'd4,
		REG_SCR_W  = 3'd5,
		REG_SCR_H  = 3'd6,
		REG_INTL   = 3'd7
	} reg_idx_t;

	// Control sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,     // wait for an input transfer
		S_EXTRACT,  // pull the next code from the bit buffer
		S_KWADD,    // KwKwK: add entry before the walk
		S_LEN_RD,   // prefix chain walk to find length / first byte
		S_LEN_WT,
		S_ADD,      // add new entry after walk
		S_PIX_RD,   // read chain down to the wanted byte
		S_PIX_WT,
		S_PIX_OUT,  // emit one pixel
		S_CLOSE     // emit closing status
	} state_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  pixel_index;
		logic [13:0] screen_x;
		logic [13:0] screen_y;
		logic        row_complete;
		logic        last;
	} result_t;

	// Table write request from sequencer to dictionary memory.
	typedef struct packed {
		logic        we;
		logic [11:0] addr;
		logic [11:0] prefix;
		logic [7:0]  suffix;
	} tbl_wr_t;

	function automatic logic [3:0] pass_start(input logic [1:0] p);
		unique case (p)
			2'd0: pass_start = 4'd0;
			2'd1: pass_start = 4'd4;
			2'd2: pass_start = 4'd2;
			default: pass_start = 4'd1;
		endcase
	endfunction

	function automatic logic [3:0] pass_step(input logic [1:0] p);
		unique case (p)
			2'd0, 2'd1: pass_step = 4'd8;
			2'd2: pass_step = 4'd4;
			default: pass_step = 4'd2;
		endcase
	endfunction

endpackage
`default_nettype wire

### rtl/gld_dict_mem.sv
// Dictionary memory: prefix and suffix tables, one write and one read port,
// read data registered. Depends on gld_pkg.
`default_nettype none
module gld_dict_mem
	import gld_pkg::*;
(
	input  wire logic        clk,
	input  wire tbl_wr_t     wr,
	input  wire logic [11:0] rd_addr,
	output logic      [11:0] rd_prefix,
	output logic      [7:0]  rd_suffix
);

	logic [11:0] prefix_mem [TABLE_ENTRIES];
	logic [7:0]  suffix_mem [TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			prefix_mem[wr.addr] <= wr.prefix;
			suffix_mem[wr.addr] <= wr.suffix;
		end
		rd_prefix <= prefix_mem[rd_addr];
		rd_suffix <= suffix_mem[rd_addr];
	end

endmodule
`default_nettype wire

### rtl/gld_raster.sv
// Raster position tracker: image column/row with interlace pass order,
// screen offset and clipping. Depends on gld_pkg.
`default_nettype none
module gld_raster
	import gld_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        restart,
	input  wire logic        advance,
	input  wire logic [15:0] image_left,
	input  wire logic [15:0] image_top,
	input  wire logic [15:0] image_width,
	input  wire logic [15:0] image_height,
	input  wire logic [14:0] screen_width,
	input  wire logic [14:0] screen_height,
	input  wire logic        interlaced,
	output logic             done,
	output logic             visible,
	output logic             row_end,
	output logic      [13:0] sx,
	output logic      [13:0] sy
);

	logic [15:0] col_q, row_q;
	logic [2:0]  pass_q;
	logic [3:0]  step_q;
	logic [16:0] sx_full, sy_full, r_next;
	logic [15:0] row_nx;
	logic [2:0]  pass_nx;
	logic [3:0]  step_nx;

	assign done    = (interlaced && pass_q[2]) || (row_q >= image_height);
	assign sx_full = {1'b0, image_left} + {1'b0, col_q};
	assign sy_full = {1'b0, image_top} + {1'b0, row_q};
	assign row_end = ({1'b0, col_q} + 17'd1) >= {1'b0, image_width};
	assign visible = (sx_full < {2'b0, screen_width}) && (sx_full < 17'(MAX_DIM))
		&& (sy_full < {2'b0, screen_height}) && (sy_full < 17'(MAX_DIM));
	assign sx = sx_full[13:0];
	assign sy = sy_full[13:0];

	// Next row: pass skipping is at most four short steps.
	always_comb begin
		pass_nx = pass_q;
		step_nx = step_q;
		if (interlaced) begin
			r_next = {1'b0, row_q} + {13'd0, step_q};
			for (int i = 0; i < 4; i++) begin
				if (!pass_nx[2] && r_next >= {1'b0, image_height}) begin
					pass_nx = pass_nx + 3'd1;
					if (!pass_nx[2]) begin
						r_next  = {13'd0, pass_start(pass_nx[1:0])};
						step_nx = pass_step(pass_nx[1:0]);
					end
				end
			end
		end else begin
			r_next = {1'b0, row_q} + 17'd1;
		end
		row_nx = r_next[16] ? 16'hFFFF : r_next[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			pass_q <= '0;
			step_q <= 4'd8;
		end else if (restart) begin
			col_q  <= '0;
			row_q  <= '0;
			pass_q <= '0;
			step_q <= 4'd8;
		end else if (advance) begin
			if (row_end) begin
				col_q  <= '0;
				row_q  <= row_nx;
				pass_q <= pass_nx;
				step_q <= step_nx;
			end else begin
				col_q <= col_q + 16'd1;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/gif_lzw_pixel_decoder.sv
// Top level of the GIF LZW pixel decoder: input/output streams, config
// registers, LZW sequencer. Depends on gld_pkg, gld_dict_mem, gld_raster.
//
// Each accepted input item yields zero or more pixel results followed by one
// closing status item with tlast set. The block handles one input item at a
// time: s_tready is high only while the sequencer is idle. Every table
// access goes through the single-read-port dictionary memory, whose read
// data is registered, so a code's length and first byte are found by a walk
// down its prefix chain, and each emitted pixel at distance d from the code's
// tail is found by a fresh walk (read issue, d chain steps, read wait,
// output). At most 63 string bytes are walked per input item; a longer
// string pauses with status 2 until a resume command. The result register
// frees the sequencer as soon as m_tready takes the held item.
// No clearing pass: table entries are only read after they are written.
`default_nettype none
module gif_lzw_pixel_decoder
	import gld_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic [1:0]  s_tuser,   // [1:0] command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [39:0] m_tdata,   // [2:0] status, [10:3] pixel_index,
	                                    // [24:11] screen_x, [38:25] screen_y,
	                                    // [39] row_complete
	output logic             m_tlast    // last
);

	// Configuration registers.
	logic [3:0]  mcs_q;
	logic [15:0] left_q, top_q, width_q, height_q;
	logic [14:0] scr_w_q, scr_h_q;
	logic        intl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcs_q <= 4'd8; left_q <= '0; top_q <= '0;
			width_q <= 16'd1; height_q <= 16'd1;
			scr_w_q <= 15'd1; scr_h_q <= 15'd1; intl_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MCS:    mcs_q    <= cfg_data[3:0];
				REG_LEFT:   left_q   <= cfg_data;
				REG_TOP:    top_q    <= cfg_data;
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_SCR_W:  scr_w_q  <= cfg_data[14:0];
				REG_SCR_H:  scr_h_q  <= cfg_data[14:0];
				REG_INTL:   intl_q   <= cfg_data[0];
			endcase
		end
	end

	// Effective code size, clamped and read live.
	logic [3:0]  mcs_eff;
	logic [12:0] cc, eoi;
	assign mcs_eff = (mcs_q < 4'd2) ? 4'd2 : (mcs_q > 4'd8) ? 4'd8 : mcs_q;
	assign cc  = 13'd1 << mcs_eff;
	assign eoi = cc + 13'd1;

	// Decoder state.
	state_t      state_q, state_d;
	logic [12:0] nfc_q;
	logic [3:0]  cw_q;
	logic [11:0] prev_code_q;
	logic        prev_valid_q;
	logic [7:0]  prev_byte_q;
	logic [19:0] acc_q;
	logic [4:0]  bcnt_q;
	logic [11:0] pend_code_q;
	logic        pend_valid_q;
	logic [12:0] pend_pos_q, pend_len_q;
	logic        ended_q;
	logic [2:0]  err_q;
	logic        refused_q;
	logic [5:0]  walked_q;
	logic        kw_q;
	logic [11:0] node_q;   // chain walk pointer
	logic [12:0] cnt_q;    // walk length or remaining steps
	logic [11:0] code_q;   // code under expansion

	// Result register.
	result_t res_q;
	logic    res_valid_q;
	logic    res_load;
	status_t close_st;

	// Dictionary memory.
	tbl_wr_t     wr;
	logic [11:0] rd_addr, rd_prefix;
	logic [7:0]  rd_suffix;

	gld_dict_mem u_mem (
		.clk       (clk),
		.wr        (wr),
		.rd_addr   (rd_addr),
		.rd_prefix (rd_prefix),
		.rd_suffix (rd_suffix)
	);

	// Raster tracker.
	logic        r_restart, r_advance, r_done, r_visible, r_row_end;
	logic [13:0] r_sx, r_sy;

	gld_raster u_raster (
		.clk           (clk),
		.arst_n        (arst_n),
		.restart       (r_restart),
		.advance       (r_advance),
		.image_left    (left_q),
		.image_top     (top_q),
		.image_width   (width_q),
		.image_height  (height_q),
		.screen_width  (scr_w_q),
		.screen_height (scr_h_q),
		.interlaced    (intl_q),
		.done          (r_done),
		.visible       (r_visible),
		.row_end       (r_row_end),
		.sx            (r_sx),
		.sy            (r_sy)
	);

	logic        in_xfer, out_free;
	cmd_t        cmd;
	logic [11:0] code_now;
	logic [12:0] code_w;
	logic [12:0] nfc_inc;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !res_valid_q || m_tready;
	assign cmd      = cmd_t'(s_tuser);
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign code_now = 12'(acc_q & ((20'd1 << cw_q) - 20'd1));
	assign code_w   = {1'b0, code_now};
	assign nfc_inc  = nfc_q + 13'd1;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					priority case (cmd)
						CMD_START: state_d = S_CLOSE;
						CMD_BYTE: state_d = (err_q != '0 || ended_q || pend_valid_q)
							? S_CLOSE : S_EXTRACT;
						default: state_d = (err_q == '0 && !ended_q && pend_valid_q)
							? S_PIX_RD : S_CLOSE;
					endcase
				end
			end
			S_EXTRACT: begin
				if ({1'b0, bcnt_q} < {1'b0, cw_q}) state_d = S_CLOSE;
				else if (code_w == cc || code_w == eoi) state_d = S_EXTRACT;
				else if (code_w > nfc_q) state_d = S_CLOSE;
				else if (!prev_valid_q) state_d = (code_w >= cc) ? S_CLOSE : S_PIX_RD;
				else if (code_w == nfc_q) state_d = S_KWADD;
				else state_d = S_LEN_RD;
			end
			S_KWADD: state_d = S_LEN_RD;
			S_LEN_RD: state_d = ({1'b0, node_q} > eoi) ? S_LEN_WT : S_ADD;
			S_LEN_WT: state_d = S_LEN_RD;
			S_ADD: state_d = S_PIX_RD;
			S_PIX_RD: begin
				if (!pend_valid_q) state_d = S_EXTRACT;
				else if (r_done) state_d = S_EXTRACT;
				else if (walked_q == 6'(MAX_BURST)) state_d = S_CLOSE;
				else state_d = S_PIX_WT;
			end
			S_PIX_WT: state_d = (cnt_q == '0) ? S_PIX_OUT : S_PIX_WT;
			S_PIX_OUT: if (out_free) state_d = S_PIX_RD;
			S_CLOSE: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
		if (err_q != '0 || ended_q) begin
			if (state_q == S_EXTRACT || state_q == S_PIX_RD) state_d = S_CLOSE;
		end
	end

	// Memory read address: chain walk pointer. Issue the string's code while
	// the walk is set up so its prefix is ready on the first wait cycle.
	always_comb begin
		rd_addr = node_q;
		if (state_q == S_PIX_RD) rd_addr = pend_code_q;
		if (state_q == S_PIX_WT && cnt_q != '0) rd_addr = rd_prefix;
	end

	// Table write: KwKwK entry before walk, ordinary entry after it.
	always_comb begin
		wr        = '0;
		wr.addr   = nfc_q[11:0];
		wr.prefix = prev_code_q;
		wr.suffix = prev_byte_q;
		if (state_q == S_KWADD && !nfc_q[12]) wr.we = 1'b1;
		if (state_q == S_ADD && !kw_q && !nfc_q[12]) begin
			wr.we     = 1'b1;
			wr.suffix = node_q[7:0];
		end
	end

	assign r_restart = in_xfer && cmd == CMD_START;
	assign r_advance = state_q == S_PIX_OUT && out_free;

	// Byte under the walk: root code or suffix of the reached node.
	logic [11:0] tail_node;
	logic [7:0]  pix_byte;
	assign tail_node = node_q;
	assign pix_byte  = ({1'b0, tail_node} < cc) ? tail_node[7:0] : rd_suffix;

	// Closing status: sticky error first, then refused byte, pause, end.
	always_comb begin
		priority if (err_q != '0) close_st = status_t'(err_q);
		else if (refused_q) close_st = ST_REFUSED;
		else if (pend_valid_q) close_st = ST_PAUSED;
		else if (ended_q) close_st = ST_ENDED;
		else close_st = ST_WANTS;
	end

	// Load the result register with a visible pixel or the closing item.
	assign res_load = out_free
		&& ((state_q == S_PIX_OUT && r_visible) || state_q == S_CLOSE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			nfc_q <= 13'd258; cw_q <= 4'd9;
			prev_code_q <= '0; prev_valid_q <= 1'b0; prev_byte_q <= '0;
			acc_q <= '0; bcnt_q <= '0;
			pend_code_q <= '0; pend_valid_q <= 1'b0; pend_pos_q <= '0; pend_len_q <= '0;
			ended_q <= 1'b0; err_q <= '0; refused_q <= 1'b0;
			walked_q <= '0; kw_q <= 1'b0; node_q <= '0; cnt_q <= '0; code_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load) res_valid_q <= 1'b1;
			else if (m_tready) res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					walked_q  <= '0;
					refused_q <= 1'b0;
					if (in_xfer) begin
						priority case (cmd)
							CMD_START: begin
								nfc_q <= cc + 13'd2; cw_q <= mcs_eff + 4'd1;
								prev_code_q <= '0; prev_valid_q <= 1'b0; prev_byte_q <= '0;
								acc_q <= '0; bcnt_q <= '0;
								pend_code_q <= '0; pend_valid_q <= 1'b0;
								pend_pos_q <= '0; pend_len_q <= '0;
								ended_q <= 1'b0; err_q <= '0;
							end
							CMD_BYTE: begin
								if (err_q == '0 && !ended_q) begin
									if (pend_valid_q) refused_q <= 1'b1;
									else begin
										acc_q  <= acc_q | (20'(s_tdata) << bcnt_q);
										bcnt_q <= bcnt_q + 5'd8;
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_EXTRACT: begin
					if (err_q == '0 && !ended_q && {1'b0, bcnt_q} >= {1'b0, cw_q}) begin
						acc_q  <= acc_q >> cw_q;
						bcnt_q <= bcnt_q - {1'b0, cw_q};
						code_q <= code_now;
						node_q <= code_now;
						cnt_q  <= 13'd1;
						kw_q   <= code_w == nfc_q;
						if (code_w == cc) begin
							nfc_q <= cc + 13'd2;
							cw_q  <= mcs_eff + 4'd1;
							prev_valid_q <= 1'b0;
						end else if (code_w == eoi) begin
							ended_q <= 1'b1;
						end else if (code_w > nfc_q) begin
							err_q <= ST_UNDEF;
						end else if (!prev_valid_q) begin
							if (code_w >= cc) err_q <= ST_NOT_ROOT;
							else begin
								prev_code_q <= code_now; prev_valid_q <= 1'b1;
								prev_byte_q <= code_now[7:0];
								pend_code_q <= code_now; pend_pos_q <= '0;
								pend_len_q <= 13'd1; pend_valid_q <= 1'b1;
							end
						end
					end
				end
				S_KWADD: begin
					if (!nfc_q[12]) begin
						nfc_q <= nfc_inc;
						if (cw_q < 4'd12 && nfc_inc == (13'd1 << cw_q)) cw_q <= cw_q + 4'd1;
					end
				end
				S_LEN_RD: ;
				S_LEN_WT: begin
					node_q <= rd_prefix;
					cnt_q  <= cnt_q + 13'd1;
				end
				S_ADD: begin
					if (!kw_q && !nfc_q[12]) begin
						nfc_q <= nfc_inc;
						if (cw_q < 4'd12 && nfc_inc == (13'd1 << cw_q)) cw_q <= cw_q + 4'd1;
					end
					prev_code_q <= code_q; prev_valid_q <= 1'b1;
					prev_byte_q <= node_q[7:0];
					pend_code_q <= code_q; pend_pos_q <= '0;
					pend_len_q <= cnt_q; pend_valid_q <= 1'b1;
				end
				S_PIX_RD: begin
					node_q <= pend_code_q;
					cnt_q  <= pend_len_q - 13'd1 - pend_pos_q;
					if (pend_valid_q && r_done) pend_valid_q <= 1'b0;
				end
				S_PIX_WT: begin
					if (cnt_q != '0) begin
						node_q <= rd_prefix;
						cnt_q  <= cnt_q - 13'd1;
					end
				end
				S_PIX_OUT: begin
					if (out_free) begin
						if (r_visible) begin
							res_q <= '{status: ST_PIXEL, pixel_index: pix_byte,
								screen_x: r_sx, screen_y: r_sy,
								row_complete: r_row_end, last: 1'b0};
						end
						walked_q   <= walked_q + 6'd1;
						pend_pos_q <= pend_pos_q + 13'd1;
						if (pend_pos_q + 13'd1 >= pend_len_q) pend_valid_q <= 1'b0;
					end
				end
				S_CLOSE: begin
					if (out_free) begin
						res_q <= '{status: close_st, pixel_index: 8'd0,
							screen_x: 14'd0, screen_y: 14'd0,
							row_complete: 1'b0, last: 1'b1};
					end
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {res_q.row_complete, res_q.screen_y, res_q.screen_x,
		res_q.pixel_index, res_q.status};
	assign m_tlast  = res_q.last;

	// Input is taken only while no result is stalled in the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!m_tvalid || m_tready))
		else $error("input taken while result held");

	// A pixel result never carries tlast.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[2:0] == ST_PIXEL) |-> !m_tlast)
		else $error("pixel marked last");

	// The code width never exceeds twelve bits.
	assert property (@(posedge clk) disable iff (!arst_n) cw_q <= 4'd12)
		else $error("code width overflow");

	// An accepted item leaves idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> state_q != S_IDLE)
		else $error("item accepted without work");

endmodule
`default_nettype wire
